// ----- src/hbp_pkg.sv -----
// Package: payload widths and opcode codes of the code bit packer.
package hbp_pkg;

   localparam int OPCODE_W = 2;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W = 32;
   localparam int CLEN_W = 6;
   localparam int BYTE_W = 8;
   localparam int VBITS_W = 4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2
   } op_type;

endpackage

// ----- src/hbp_if.sv -----
// Interfaces: request and response channels of the code bit packer.
interface hbp_req_if;
   logic                             valid;
   logic                             ready;
   logic [hbp_pkg::OPCODE_W-1:0]     opcode;
   logic [hbp_pkg::SYMBOL_W-1:0]     symbol;
   logic [hbp_pkg::CODE_W-1:0]       code_bits;
   logic [hbp_pkg::CLEN_W-1:0]       code_length;

   modport source (output valid, output opcode, output symbol, output code_bits,
                   output code_length, input ready);
   modport sink (input valid, input opcode, input symbol, input code_bits,
                 input code_length, output ready);
endinterface

interface hbp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [hbp_pkg::BYTE_W-1:0]       out_byte;
   logic [hbp_pkg::VBITS_W-1:0]      valid_bits;
   logic                             last;

   modport source (output valid, output out_byte, output valid_bits, output last,
                   input ready);
   modport sink (input valid, input out_byte, input valid_bits, input last,
                 output ready);
endinterface

// ----- src/hbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hbp_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/huffman_code_bit_packer_core.sv -----
// Top level: code table lookup and bit packing into bytes.
// Pipeline: an encode or flush passes the table read and stage 1 registers into the byte emitter.
// Throughput: one item per cycle and one result per cycle while the response side is ready; an
// encode giving k bytes holds the next result-giving item until the emitter takes its last byte.
// Reset: synchronous; clears table valid bits at once, pending bits and the pipeline.
module huffman_code_bit_packer_core #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic     clock,
   input  logic     reset,
   hbp_req_if.sink  req_ch,
   hbp_rsp_if.source rsp_ch
);

   localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
   localparam int ENTRY_W = hbp_pkg::CODE_W + LEN_W;
   localparam int NB = (7 + MAX_CODE_LEN + 7) / 8;
   localparam int FW = 8 * NB;
   localparam int TW = $clog2(FW + 1);
   localparam int CNT_W = $clog2(NB + 1);

   // stage 0
   logic                          req_acc;
   logic                          sym_ok;
   logic [hbp_pkg::CLEN_W-1:0]    len_sat;
   logic                          wr_en;
   logic                          rd_en;
   logic [ENTRY_W-1:0]            rd_data;
   logic [SYMBOL_COUNT-1:0]       vld_ff, vld_in;
   logic                          vld_rd_ff, vld_rd_in;

   // stage 1
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_flush_ff, s1_flush_in;
   logic                          s1_adv;
   logic                          s1_emit;
   logic [LEN_W-1:0]              clen;
   logic [hbp_pkg::CODE_W-1:0]    rd_code;
   logic [hbp_pkg::CODE_W-1:0]    code_mask;
   logic [FW-1:0]                 code_ext;
   logic [TW-1:0]                 total;
   logic [TW-1:0]                 sh;
   logic [FW-1:0]                 frame;
   logic [FW-1:0]                 frame_sh;
   logic [CNT_W-1:0]              nbytes;
   logic [7:0]                    pend_byte_ff, pend_byte_in;
   logic [2:0]                    pend_cnt_ff, pend_cnt_in;

   // emitter
   logic                          emit_free;
   logic                          rsp_acc;
   logic [FW-1:0]                 em_buf_ff, em_buf_in;
   logic [CNT_W-1:0]              em_cnt_ff, em_cnt_in;
   logic [hbp_pkg::VBITS_W-1:0]   em_vb_ff, em_vb_in;

   assign req_ch.ready = !s1_valid_ff || s1_adv;
   assign req_acc = req_ch.valid && req_ch.ready;
   assign sym_ok = {1'b0, req_ch.symbol} < 9'(SYMBOL_COUNT);
   assign len_sat = (req_ch.code_length > 6'(MAX_CODE_LEN)) ? 6'(MAX_CODE_LEN)
                                                            : req_ch.code_length;
   assign wr_en = req_acc && (req_ch.opcode == hbp_pkg::OP_LOAD) && sym_ok;
   assign rd_en = req_acc && (req_ch.opcode == hbp_pkg::OP_ENCODE);

   hbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_ch.symbol[AW-1:0]),
      .wr_data ({LEN_W'(len_sat), req_ch.code_bits}),
      .rd_en   (rd_en),
      .rd_addr (req_ch.symbol[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[req_ch.symbol[AW-1:0]] = 1'b1;
      end
      vld_rd_in = rd_en ? vld_ff[req_ch.symbol[AW-1:0]] : vld_rd_ff;
   end

   always_comb begin
      s1_flush_in = s1_flush_ff;
      if (req_acc) begin
         s1_valid_in = ((req_ch.opcode == hbp_pkg::OP_ENCODE) && sym_ok)
                       || (req_ch.opcode == hbp_pkg::OP_FLUSH);
         s1_flush_in = (req_ch.opcode == hbp_pkg::OP_FLUSH);
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // merge pending bits with the looked-up code
   assign rd_code = rd_data[hbp_pkg::CODE_W-1:0];
   assign clen = (vld_rd_ff && !s1_flush_ff) ? rd_data[ENTRY_W-1:hbp_pkg::CODE_W] : '0;
   assign code_mask = (7'(clen) >= 7'd32) ? '1 : ~({hbp_pkg::CODE_W{1'b1}} << clen);
   assign code_ext = FW'(rd_code & code_mask);
   assign total = TW'(pend_cnt_ff) + TW'(clen);
   assign sh = TW'(FW) - total;
   assign frame = {pend_byte_ff, {(FW-8){1'b0}}} | (code_ext << sh);
   assign nbytes = CNT_W'(total >> 3);
   assign frame_sh = frame << {nbytes, 3'b000};

   assign s1_emit = s1_flush_ff ? (pend_cnt_ff != 3'd0) : (nbytes != '0);
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;
   assign emit_free = (em_cnt_ff == '0) || ((em_cnt_ff == CNT_W'(1)) && rsp_ch.ready);
   assign s1_adv = s1_valid_ff && (!s1_emit || emit_free);

   always_comb begin
      pend_byte_in = pend_byte_ff;
      pend_cnt_in = pend_cnt_ff;
      if (s1_adv) begin
         if (s1_flush_ff) begin
            pend_byte_in = '0;
            pend_cnt_in = '0;
         end else begin
            pend_byte_in = frame_sh[FW-1 -: 8];
            pend_cnt_in = total[2:0];
         end
      end
   end

   always_comb begin
      em_buf_in = em_buf_ff;
      em_cnt_in = em_cnt_ff;
      em_vb_in = em_vb_ff;
      if (s1_adv && s1_emit) begin
         em_buf_in = frame;
         em_cnt_in = s1_flush_ff ? CNT_W'(1) : nbytes;
         em_vb_in = s1_flush_ff ? {1'b0, pend_cnt_ff} : 4'd8;
      end else if (rsp_acc) begin
         em_buf_in = em_buf_ff << 8;
         em_cnt_in = em_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         s1_valid_ff <= 1'b0;
         pend_byte_ff <= '0;
         pend_cnt_ff <= '0;
         em_cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         s1_valid_ff <= s1_valid_in;
         pend_byte_ff <= pend_byte_in;
         pend_cnt_ff <= pend_cnt_in;
         em_cnt_ff <= em_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      vld_rd_ff <= vld_rd_in;
      s1_flush_ff <= s1_flush_in;
      em_buf_ff <= em_buf_in;
      em_vb_ff <= em_vb_in;
   end

   assign rsp_ch.valid = (em_cnt_ff != '0);
   assign rsp_ch.out_byte = em_buf_ff[FW-1 -: 8];
   assign rsp_ch.valid_bits = em_vb_ff;
   assign rsp_ch.last = (em_cnt_ff == CNT_W'(1));

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> s1_valid_ff)
      else $error("stalled stage 1 item dropped");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_flush_ff) |=> (pend_cnt_ff == 3'd0))
      else $error("pending bits survive a flush");

   a_em_bound: assert property (@(posedge clock) disable iff (reset)
      em_cnt_ff <= CNT_W'(NB))
      else $error("emitter byte count out of range");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (em_cnt_ff > CNT_W'(1)) |-> !(s1_adv && s1_emit))
      else $error("emitter overwritten while bytes remain");

endmodule
